/* rtl/hrob_pkg.sv */
`default_nettype none
package hrob_pkg;

  localparam int RING_DEPTH = 4096;
  localparam int MAX_RUN    = 64;

  localparam int AW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW     = $clog2(RING_DEPTH + 1);
  localparam int OFF_W  = 64;
  localparam int LEN_W  = 7;
  localparam int BYTE_W = 8;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [OFF_W-1:0] total;
    logic [CW-1:0]    held;
    logic [AW-1:0]    oldest_ptr;
  } hrob_status_t;

  // advance a ring pointer, wrapping at the depth
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage
`default_nettype wire

/* rtl/hrob_if.sv */
`default_nettype none
interface hrob_in_if import hrob_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [BYTE_W-1:0] data_byte;
  logic [OFF_W-1:0]  start_offset;
  logic [LEN_W-1:0]  read_len;

  modport source (output valid, cmd, data_byte, start_offset, read_len, input ready);
  modport sink   (input valid, cmd, data_byte, start_offset, read_len, output ready);
endinterface

interface hrob_out_if import hrob_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [OFF_W-1:0]  byte_offset;
  logic              has_data;
  logic              gap;
  logic              last;

  modport source (output valid, out_byte, byte_offset, has_data, gap, last, input ready);
  modport sink   (input valid, out_byte, byte_offset, has_data, gap, last, output ready);
endinterface
`default_nettype wire

/* rtl/hrob_store.sv */
`default_nettype none
module hrob_store import hrob_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [BYTE_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output      logic [BYTE_W-1:0] rd_data,
  output      hrob_status_t      status
);

  logic [BYTE_W-1:0] mem [RING_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  logic [OFF_W-1:0] total_r, total_nxt;
  logic [CW-1:0]    held_r, held_nxt;
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    oldest_ptr_r, oldest_ptr_nxt;
  logic             full;

  assign full = (held_r == CW'(RING_DEPTH));

  always_comb begin
    total_nxt      = total_r;
    held_nxt       = held_r;
    wr_ptr_nxt     = wr_ptr_r;
    oldest_ptr_nxt = oldest_ptr_r;
    if (wr_en) begin
      total_nxt  = total_r + 1'b1;
      wr_ptr_nxt = ptr_inc(wr_ptr_r);
      // once full, the oldest byte gets overwritten: advance its pointer
      if (full) begin
        oldest_ptr_nxt = ptr_inc(oldest_ptr_r);
      end else begin
        held_nxt = held_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r      <= '0;
      held_r       <= '0;
      wr_ptr_r     <= '0;
      oldest_ptr_r <= '0;
    end else begin
      total_r      <= total_nxt;
      held_r       <= held_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      oldest_ptr_r <= oldest_ptr_nxt;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data           = rd_data_r;
  assign status.total      = total_r;
  assign status.held       = held_r;
  assign status.oldest_ptr = oldest_ptr_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(RING_DEPTH))
    else $error("held count above ring depth");

  a_oldest_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !full |-> oldest_ptr_r == '0)
    else $error("oldest pointer moved before the ring filled");

endmodule
`default_nettype wire

/* rtl/history_ring_offset_buffer.sv */
// Append: one word per cycle while idle, byte written at the accept edge, no result.
// Read: setup states S_CLAMP (clamp) and S_SIZE (size/address), then one result
// word per cycle from the single ring read port while the output is not stalled;
// the first word is registered from S_RUN, and a read emits 1 to 64 words.
// Reset (rst_n low, synchronous): clears stream total, held count, pointers, FSM,
// output valid. Ring contents are not cleared; only written entries are ever read.
`default_nettype none
module history_ring_offset_buffer import hrob_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  hrob_in_if.sink   in_ch,
  hrob_out_if.source out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLAMP,
    S_SIZE,
    S_RUN
  } state_t;

  localparam int SUM_W = AW + 1;

  state_t            state_r, state_nxt;
  logic [OFF_W-1:0]  start_r, start_nxt;     // clamped start, then the running offset
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              gap_r, gap_nxt;
  logic [OFF_W-1:0]  oldest_r, oldest_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic              empty_r, empty_nxt;
  logic [AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OFF_W-1:0]  out_off_r, out_off_nxt;
  logic              out_has_r, out_has_nxt;
  logic              out_gap_r, out_gap_nxt;
  logic              out_last_r, out_last_nxt;

  hrob_status_t      status;
  logic [BYTE_W-1:0] rd_data;
  logic              acc;
  logic              wr_en;
  logic              rd_en;
  logic              issue;
  logic              last_now;
  logic [OFF_W-1:0]  avail;
  logic [AW-1:0]     rel;
  logic [SUM_W-1:0]  addr_sum;

  // ring memory and stream counters
  hrob_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_data (in_ch.data_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data),
    .status  (status)
  );

  // take a new word whenever the sequencer is idle, even with a result still waiting
  assign in_ch.ready = (state_r == S_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign wr_en       = acc && (in_ch.cmd == CMD_APPEND);

  // issue one result per cycle while the output slot frees up
  assign issue    = (state_r == S_RUN) && (!out_valid_r || out_ch.ready);
  assign rd_en    = issue && !empty_r;
  assign last_now = empty_r || (rem_r == LEN_W'(1));

  // bytes between the clamped start and the newest byte
  assign avail = status.total - start_r;
  // distance from the oldest held byte; below the depth whenever data is returned
  assign rel      = AW'(start_r - oldest_r);
  assign addr_sum = {1'b0, status.oldest_ptr} + {1'b0, rel};

  always_comb begin
    state_nxt     = state_r;
    start_nxt     = start_r;
    len_nxt       = len_r;
    gap_nxt       = gap_r;
    oldest_nxt    = oldest_r;
    rem_nxt       = rem_r;
    empty_nxt     = empty_r;
    rd_addr_nxt   = rd_addr_r;
    out_off_nxt   = out_off_r;
    out_has_nxt   = out_has_r;
    out_gap_nxt   = out_gap_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (state_r)
      S_IDLE: begin
        if (acc && (in_ch.cmd == CMD_READ)) begin
          start_nxt = in_ch.start_offset;
          // saturate the run length
          len_nxt   = (in_ch.read_len > LEN_W'(MAX_RUN)) ? LEN_W'(MAX_RUN) : in_ch.read_len;
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        // raise a start older than the oldest held byte and flag the gap
        oldest_nxt = status.total - OFF_W'(status.held);
        if (start_r < oldest_nxt) begin
          start_nxt = oldest_nxt;
          gap_nxt   = 1'b1;
        end else begin
          gap_nxt   = 1'b0;
        end
        state_nxt = S_SIZE;
      end
      S_SIZE: begin
        // nothing to give: one empty word at the clamped start
        empty_nxt   = (start_r >= status.total) || (len_r == '0);
        rem_nxt     = (avail < OFF_W'(len_r)) ? LEN_W'(avail) : len_r;
        rd_addr_nxt = (addr_sum >= SUM_W'(RING_DEPTH)) ?
                      AW'(addr_sum - SUM_W'(RING_DEPTH)) : AW'(addr_sum);
        state_nxt   = S_RUN;
      end
      S_RUN: begin
        if (issue) begin
          out_valid_nxt = 1'b1;
          out_off_nxt   = start_r;
          out_has_nxt   = !empty_r;
          out_gap_nxt   = gap_r;
          out_last_nxt  = last_now;
          start_nxt     = start_r + 1'b1;
          rd_addr_nxt   = ptr_inc(rd_addr_r);
          rem_nxt       = rem_r - 1'b1;
          if (last_now) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    start_r    <= start_nxt;
    len_r      <= len_nxt;
    gap_r      <= gap_nxt;
    oldest_r   <= oldest_nxt;
    rem_r      <= rem_nxt;
    empty_r    <= empty_nxt;
    rd_addr_r  <= rd_addr_nxt;
    out_off_r  <= out_off_nxt;
    out_has_r  <= out_has_nxt;
    out_gap_r  <= out_gap_nxt;
    out_last_r <= out_last_nxt;
  end

  // the memory read register holds the byte until the next issue
  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_has_r ? rd_data : '0;
  assign out_ch.byte_offset = out_off_r;
  assign out_ch.has_data    = out_has_r;
  assign out_ch.gap         = out_gap_r;
  assign out_ch.last        = out_last_r;

  a_read_held: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (start_r < status.total) && (start_r >= oldest_r))
    else $error("ring read outside the held window");

  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) && !empty_r |-> rem_r != '0)
    else $error("run active with no bytes left");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    issue && last_now |=> (state_r == S_IDLE) && out_ch.valid && out_ch.last)
    else $error("final word did not end the run");

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
module tb;
  import hrob_pkg::*;

  // Stimulus shape: a directed opener, a mixed stretch while the ring is still
  // filling, one long append burst that wraps the ring, then a mixed stretch
  // against a full ring where reads fall off the oldest byte.
  localparam int MIX_FILLING  = 150;
  localparam int FILL_BURST   = RING_DEPTH + 100;
  localparam int MIX_FULL     = 400;
  localparam int PHASE_SPAN   = 190;
  localparam int DRAIN_CYCLES = MAX_RUN + 16;

  typedef struct {
    cmd_t              cmd;
    bit [BYTE_W-1:0]   data_byte;
    bit [OFF_W-1:0]    start_offset;
    bit [LEN_W-1:0]    read_len;
    int unsigned       phase;
  } stream_item_t;

  typedef struct {
    bit [BYTE_W-1:0] out_byte;
    bit [OFF_W-1:0]  byte_offset;
    bit              has_data;
    bit              gap;
    bit              last;
  } history_word_t;

  logic clk;
  logic rst_n;

  hrob_in_if  in_ch();
  hrob_out_if out_ch();

  history_ring_offset_buffer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Items waiting to be offered, and result words the block still owes.
  stream_item_t  stream_items[$];
  history_word_t owed_words[$];
  bit            failed;
  int unsigned   cur_phase;

  // Shadow of the ring as the block should hold it after each accepted word.
  bit [BYTE_W-1:0] shadow_ring [RING_DEPTH];
  bit [OFF_W-1:0]  shadow_total;
  bit [OFF_W-1:0]  shadow_held;

  // Bookkeeping of the stream while it is being built, used to aim read offsets.
  bit [OFF_W-1:0]  plan_total;
  bit [OFF_W-1:0]  plan_held;
  int unsigned     plan_seq;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Hold reset low from time zero, with every block input at a known value.
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_APPEND;
    in_ch.data_byte    = '0;
    in_ch.start_offset = '0;
    in_ch.read_len     = '0;
    out_ch.ready       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Apply one accepted word to the shadow ring and queue the result words it owes.
  task automatic history_step(input stream_item_t it);
    bit [OFF_W-1:0] oldest;
    bit [OFF_W-1:0] first;
    bit [OFF_W-1:0] run;
    bit [OFF_W-1:0] i;
    bit             gap;
    history_word_t  w;
    if (it.cmd == CMD_APPEND) begin
      shadow_ring[shadow_total % 64'(RING_DEPTH)] = it.data_byte;
      shadow_total = shadow_total + 1;
      if (shadow_held < 64'(RING_DEPTH)) shadow_held = shadow_held + 1;
    end else begin
      oldest = shadow_total - shadow_held;
      first  = it.start_offset;
      gap    = 1'b0;
      // raise a start older than the oldest held byte and flag it
      if (first < oldest) begin
        first = oldest;
        gap   = 1'b1;
      end
      run = (it.read_len > MAX_RUN) ? 64'(MAX_RUN) : 64'(it.read_len);
      if (first >= shadow_total || run == 0) begin
        // nothing to give: one empty word at the raised start
        w.out_byte    = '0;
        w.byte_offset = first;
        w.has_data    = 1'b0;
        w.gap         = gap;
        w.last        = 1'b1;
        owed_words.push_back(w);
      end else begin
        if (shadow_total - first < run) run = shadow_total - first;
        for (i = 0; i < run; i++) begin
          w.out_byte    = shadow_ring[(first + i) % 64'(RING_DEPTH)];
          w.byte_offset = first + i;
          w.has_data    = 1'b1;
          w.gap         = gap;
          w.last        = (i + 1 == run);
          owed_words.push_back(w);
        end
      end
    end
  endtask

  // Percent of cycles a side stays idle in a given idling phase.
  function automatic int unsigned idle_pct(input bit receiver, input int unsigned ph);
    case (ph)
      0:       return receiver ? 88 : 20;
      1:       return receiver ? 20 : 88;
      default: return 0;
    endcase
  endfunction

  task automatic push_item(input stream_item_t it, input bit counted);
    it.phase = (plan_seq / PHASE_SPAN > 2) ? 2 : plan_seq / PHASE_SPAN;
    if (counted) plan_seq++;
    if (it.cmd == CMD_APPEND) begin
      plan_total = plan_total + 1;
      if (plan_held < 64'(RING_DEPTH)) plan_held = plan_held + 1;
    end
    stream_items.push_back(it);
  endtask

  // Unused fields carry random values; the block must ignore them.
  task automatic add_append(input bit [BYTE_W-1:0] b, input bit counted);
    stream_item_t it;
    it.cmd          = CMD_APPEND;
    it.data_byte    = b;
    it.start_offset = {$urandom, $urandom};
    it.read_len     = LEN_W'($urandom);
    it.phase        = 0;
    push_item(it, counted);
  endtask

  task automatic add_read(input bit [OFF_W-1:0] s, input bit [LEN_W-1:0] len);
    stream_item_t it;
    it.cmd          = CMD_READ;
    it.data_byte    = BYTE_W'($urandom);
    it.start_offset = s;
    it.read_len     = len;
    it.phase        = 0;
    push_item(it, 1'b1);
  endtask

  // Aim most reads at the held window and its edges, a few anywhere.
  function automatic bit [OFF_W-1:0] pick_start();
    bit [OFF_W-1:0] oldest;
    int unsigned    roll;
    oldest = plan_total - plan_held;
    roll   = $urandom_range(0, 99);
    if (roll < 35 && plan_held != 0) return oldest + $urandom_range(0, 32'(plan_held - 1));
    if (roll < 50) return oldest - $urandom_range(1, 80);
    if (roll < 62) return plan_total - $urandom_range(0, 70);
    if (roll < 68) return plan_total + $urandom_range(0, 2);
    // straddle the point where the ring index wraps
    if (roll < 76) return {plan_total[OFF_W-1:AW], AW'(0)} - $urandom_range(1, 63);
    if (roll < 82) return oldest;
    if (roll < 88) return '0;
    if (roll < 94) return ~64'($urandom_range(0, 3));
    return {$urandom, $urandom};
  endfunction

  function automatic bit [LEN_W-1:0] pick_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return LEN_W'($urandom_range(1, MAX_RUN));
    if (roll < 80) return '0;
    if (roll < 90) return LEN_W'($urandom_range(MAX_RUN + 1, 127));
    return ($urandom_range(0, 1) != 0) ? LEN_W'(1) : LEN_W'(MAX_RUN);
  endfunction

  initial begin : build_stream
    int k;
    // empty ring: nothing held anywhere
    add_read('0, LEN_W'(1));
    add_read('1, LEN_W'(127));
    add_append(8'h00, 1'b1);
    add_append(8'hFF, 1'b1);
    add_append(8'hA5, 1'b1);
    add_append(8'h5A, 1'b1);
    add_read(64'd0, LEN_W'(64));
    add_read(64'd0, LEN_W'(0));
    add_read(64'd2, LEN_W'(1));
    add_read(64'd3, LEN_W'(127));
    add_read(64'd0, LEN_W'(65));
    // start exactly one past the newest offset, then beyond it
    add_read(64'd4, LEN_W'(5));
    add_read(64'd5, LEN_W'(1));
    add_read(64'h8000_0000_0000_0000, LEN_W'(64));
    add_read(64'd1, LEN_W'(2));
    for (k = 0; k < MIX_FILLING; k++) begin
      if ($urandom_range(0, 99) < 55) add_append(BYTE_W'($urandom), 1'b1);
      else add_read(pick_start(), pick_len());
    end
    // wrap the ring so that old bytes get overwritten
    for (k = 0; k < FILL_BURST; k++) add_append(BYTE_W'($urandom), 1'b0);
    add_read('0, LEN_W'(64));
    add_read(plan_total - plan_held - 1, LEN_W'(3));
    add_read(plan_total - 1, LEN_W'(64));
    add_read(plan_total - plan_held, LEN_W'(0));
    add_read('1, LEN_W'(1));
    for (k = 0; k < MIX_FULL; k++) begin
      if ($urandom_range(0, 99) < 50) add_append(BYTE_W'($urandom), 1'b1);
      else add_read(pick_start(), pick_len());
    end
  end

  // Offer the front item; on acceptance, predict it and advance to the next.
  always @(posedge clk) begin : feed_stream
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) history_step(stream_items.pop_front());
      // hold the current word until it is taken
      if (!in_ch.valid || in_ch.ready) begin
        if (stream_items.size() != 0 &&
            $urandom_range(0, 99) >= idle_pct(1'b0, stream_items[0].phase)) begin
          in_ch.valid        <= 1'b1;
          in_ch.cmd          <= stream_items[0].cmd;
          in_ch.data_byte    <= stream_items[0].data_byte;
          in_ch.start_offset <= stream_items[0].start_offset;
          in_ch.read_len     <= stream_items[0].read_len;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      if (stream_items.size() != 0) cur_phase <= stream_items[0].phase;
    end
  end

  // Check each accepted result word against the oldest owed one; stall at random.
  always @(posedge clk) begin : take_results
    history_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_words.size() == 0) begin
          failed = 1'b1;
          $error("result word with nothing owed, byte_offset %0h", out_ch.byte_offset);
        end else begin
          want = owed_words.pop_front();
          if (out_ch.out_byte !== want.out_byte) begin
            failed = 1'b1;
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_ch.out_byte);
          end
          if (out_ch.byte_offset !== want.byte_offset) begin
            failed = 1'b1;
            $error("byte_offset: expected %0h, got %0h", want.byte_offset,
                   out_ch.byte_offset);
          end
          if (out_ch.has_data !== want.has_data) begin
            failed = 1'b1;
            $error("has_data: expected %0b, got %0b", want.has_data, out_ch.has_data);
          end
          if (out_ch.gap !== want.gap) begin
            failed = 1'b1;
            $error("gap: expected %0b, got %0b", want.gap, out_ch.gap);
          end
          if (out_ch.last !== want.last) begin
            failed = 1'b1;
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= idle_pct(1'b1, cur_phase));
    end
  end

  // Drain: wait for every item to go in and every owed word to come out,
  // then watch a little longer for stray words.
  initial begin : finish_run
    wait (rst_n === 1'b1);
    while (stream_items.size() != 0 || owed_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && owed_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Give up well beyond the slowest correct run.
  initial begin : watchdog
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* history_ring_offset_buffer.f */
rtl/hrob_pkg.sv
rtl/hrob_if.sv
rtl/hrob_store.sv
rtl/history_ring_offset_buffer.sv
bench/tb.sv
